FILE: design/psv_pkg.sv
// shared types, codes and the sequencer program of the plucked string voice
`timescale 1ns / 1ps

package psv_pkg;

   typedef enum logic [1:0] {
      OP_RESTART = 2'd0,
      OP_LOAD    = 2'd1,
      OP_TICK    = 2'd2
   } opcode_type;

   localparam logic CSR_STRING_LENGTH = 1'b0;
   localparam logic CSR_DECAY_GAIN    = 1'b1;

   localparam int SAMPLE_W = 16;
   localparam int LENGTH_W = 18;
   localparam int GAIN_W   = 16;

   typedef enum logic [2:0] {
      STEP_IDLE    = 3'd0,
      STEP_RESTART = 3'd1,
      STEP_LOAD    = 3'd2,
      STEP_FETCH   = 3'd3,
      STEP_NEAR    = 3'd4,
      STEP_FAR     = 3'd5,
      STEP_AVERAGE = 3'd6,
      STEP_STORE   = 3'd7
   } step_type;

   typedef enum logic [1:0] {
      RD_NONE  = 2'd0,
      RD_WHOLE = 2'd1,
      RD_NEXT  = 2'd2
   } rd_sel_type;

   typedef enum logic {
      MA_DATA = 1'b0,
      MA_AVG  = 1'b1
   } mul_a_sel_type;

   typedef enum logic [1:0] {
      MB_ONEFRAC = 2'd0,
      MB_FRAC    = 2'd1,
      MB_GAIN    = 2'd2
   } mul_b_sel_type;

   typedef enum logic [1:0] {
      ACC_HOLD = 2'd0,
      ACC_LOAD = 2'd1,
      ACC_ADD  = 2'd2
   } acc_op_type;

   typedef enum logic [1:0] {
      COND_NONE     = 2'd0,
      COND_DISPATCH = 2'd1,
      COND_OUT_FREE = 2'd2
   } cond_type;

   typedef struct packed {
      rd_sel_type    rd_sel;
      mul_a_sel_type mul_a_sel;
      mul_b_sel_type mul_b_sel;
      acc_op_type    acc_op;
      logic          latch_x;
      logic          write_back;
      logic          do_restart;
      logic          do_load;
      cond_type      cond;
      step_type      next_step;
   } uop_type;

   // control store: one word per step
   function automatic uop_type uop_rom(input step_type step);
      uop_type w;
      w = '{RD_NONE, MA_DATA, MB_ONEFRAC, ACC_HOLD, 1'b0, 1'b0, 1'b0, 1'b0,
            COND_NONE, STEP_IDLE};
      case (step)
         STEP_IDLE: begin
            w.cond = COND_DISPATCH;
         end
         STEP_RESTART: begin
            w.do_restart = 1'b1;
         end
         STEP_LOAD: begin
            w.do_load = 1'b1;
         end
         STEP_FETCH: begin
            w.rd_sel    = RD_WHOLE;
            w.next_step = STEP_NEAR;
         end
         STEP_NEAR: begin
            w.rd_sel    = RD_NEXT;
            w.mul_b_sel = MB_ONEFRAC;
            w.acc_op    = ACC_LOAD;
            w.next_step = STEP_FAR;
         end
         STEP_FAR: begin
            w.mul_b_sel = MB_FRAC;
            w.acc_op    = ACC_ADD;
            w.next_step = STEP_AVERAGE;
         end
         STEP_AVERAGE: begin
            w.latch_x   = 1'b1;
            w.next_step = STEP_STORE;
         end
         STEP_STORE: begin
            w.mul_a_sel  = MA_AVG;
            w.mul_b_sel  = MB_GAIN;
            w.write_back = 1'b1;
            w.cond       = COND_OUT_FREE;
         end
         default: begin
            w.next_step = STEP_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

FILE: design/plucked_string_voice.sv
// top level of the plucked string voice: sequencer, delay ring and datapath
`timescale 1ns / 1ps

// One Karplus-Strong string. A restart or a load passes through its own step
// before the next accept; a tick passes through dispatch, two ring reads
// through the single registered read port, two interpolation products and
// one gain product through one shared multiplier, and waits before its store
// only while the previous output sample is still stalled. The delay ring is
// not cleared after reset: every entry must be loaded before it is read.
// Configuration writes take effect on the next cycle; string length is used
// at the next restart.
module plucked_string_voice
   import psv_pkg::*;
#(
   parameter int MAX_LENGTH    = 1024,
   parameter int FRACTION_BITS = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [1:0]                  req_opcode,
   input  logic signed [SAMPLE_W-1:0]  req_excitation_sample,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [SAMPLE_W-1:0]  rsp_sample,
   input  logic                        csr_write_enable,
   input  logic                        csr_index,
   input  logic [LENGTH_W-1:0]         csr_wdata
);

   localparam int F    = FRACTION_BITS;
   localparam int AW   = $clog2(MAX_LENGTH);
   localparam int NW   = $clog2(MAX_LENGTH + 1);
   localparam int RPW  = AW + F;
   localparam int BW   = (F + 1 > GAIN_W) ? F + 1 : GAIN_W;
   localparam int PW   = SAMPLE_W + BW + 1;
   localparam int ONE  = 1 << F;
   localparam int HALF = ONE >> 1;

   // configuration
   logic [LENGTH_W-1:0] string_length_ff;
   logic [GAIN_W-1:0]   decay_gain_ff;

   // voice state
   logic [NW-1:0]              buf_len_ff, buf_len_in;
   logic [AW-1:0]              wp_ff, wp_in;
   logic [RPW-1:0]             rp_ff, rp_in;
   logic signed [SAMPLE_W-1:0] prev_ff, prev_in;
   logic [AW-1:0]              lp_ff, lp_in;

   // sequencer
   step_type step_ff, step_in;
   uop_type  uop;

   // datapath registers
   logic signed [SAMPLE_W-1:0] sample_ff;
   logic signed [SAMPLE_W-1:0] rd_data_ff;
   logic signed [PW-1:0]       acc_ff;
   logic signed [SAMPLE_W-1:0] x_ff, x_in;
   logic signed [SAMPLE_W-1:0] avg_ff, avg_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] rsp_data_ff;

   // memory port
   logic signed [SAMPLE_W-1:0] mem [MAX_LENGTH];
   logic                       mem_we;
   logic [AW-1:0]              mem_waddr;
   logic signed [SAMPLE_W-1:0] mem_wdata;
   logic                       mem_re;
   logic [AW-1:0]              mem_raddr;

   logic          req_accept;
   logic          out_free;
   logic [NW-1:0] n_w, n_m1_w, whole_p1;
   logic [AW-1:0] whole_raw, whole_c, next_c, wp_c, lp_c;
   logic [NW-1:0] lp_p1;
   logic [F-1:0]  frac;
   logic [F:0]    onefrac;
   logic signed [SAMPLE_W-1:0] mul_a;
   logic [BW-1:0]              mul_b;
   logic signed [PW-1:0]       prod, acc_sh, prod_sh;
   logic signed [SAMPLE_W:0]   pair_sum;
   logic signed [SAMPLE_W-1:0] stored;
   logic [31:0]                rounded, limit;
   logic [AW-1:0]              rounded_c;

   assign req_accept = req_valid && !req_stall;
   assign req_stall  = (step_ff != STEP_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_sample = rsp_data_ff;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign uop        = uop_rom(step_ff);

   // effective ring length, a never-restarted voice acts as length one
   assign n_w       = (buf_len_ff == '0) ? NW'(1) : buf_len_ff;
   assign n_m1_w    = n_w - NW'(1);
   assign whole_raw = rp_ff[RPW-1:F];
   assign whole_c   = (NW'(whole_raw) >= n_w) ? n_m1_w[AW-1:0] : whole_raw;
   assign whole_p1  = NW'(whole_c) + NW'(1);
   assign next_c    = (whole_p1 >= n_w) ? '0 : whole_p1[AW-1:0];
   assign frac      = rp_ff[F-1:0];
   assign onefrac   = {1'b1, {F{1'b0}}} - {1'b0, frac};
   assign wp_c      = (NW'(wp_ff) >= n_w) ? n_m1_w[AW-1:0] : wp_ff;
   assign lp_c      = (NW'(lp_ff) >= n_w) ? '0 : lp_ff;
   assign lp_p1     = NW'(lp_c) + NW'(1);

   // shared multiplier
   always_comb begin
      mul_a = (uop.mul_a_sel == MA_AVG) ? avg_ff : rd_data_ff;
      case (uop.mul_b_sel)
         MB_ONEFRAC: mul_b = BW'(onefrac);
         MB_FRAC:    mul_b = BW'(frac);
         MB_GAIN:    mul_b = BW'(decay_gain_ff);
         default:    mul_b = '0;
      endcase
   end

   assign prod = mul_a * $signed({1'b0, mul_b});

   // interpolated sample with saturation, then the two-tap average
   always_comb begin
      acc_sh = acc_ff >>> F;
      if (&acc_sh[PW-1:SAMPLE_W-1] || ~|acc_sh[PW-1:SAMPLE_W-1]) begin
         x_in = acc_sh[SAMPLE_W-1:0];
      end else begin
         x_in = acc_sh[PW-1] ? 16'sh8000 : 16'sh7fff;
      end
      pair_sum = {x_in[SAMPLE_W-1], x_in} + {prev_ff[SAMPLE_W-1], prev_ff};
      avg_in   = pair_sum[SAMPLE_W:1];
   end

   always_comb begin
      prod_sh = prod >>> GAIN_W;
      if (&prod_sh[PW-1:SAMPLE_W-1] || ~|prod_sh[PW-1:SAMPLE_W-1]) begin
         stored = prod_sh[SAMPLE_W-1:0];
      end else begin
         stored = prod_sh[PW-1] ? 16'sh8000 : 16'sh7fff;
      end
   end

   // restart sizing
   always_comb begin
      rounded = (32'(string_length_ff) + 32'(HALF)) >> F;
      if (rounded > 32'(MAX_LENGTH - 1)) begin
         rounded_c = AW'(MAX_LENGTH - 1);
      end else begin
         rounded_c = rounded[AW-1:0];
      end
      limit = ((32'(rounded_c) + 32'd1) << F) - 32'd1;
   end

   // sequencer and state updates
   always_comb begin
      step_in      = step_ff;
      buf_len_in   = buf_len_ff;
      wp_in        = wp_ff;
      rp_in        = rp_ff;
      prev_in      = prev_ff;
      lp_in        = lp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      mem_we       = 1'b0;
      mem_waddr    = wp_c;
      mem_wdata    = stored;
      mem_re       = (uop.rd_sel != RD_NONE);
      mem_raddr    = (uop.rd_sel == RD_NEXT) ? next_c : whole_c;

      case (uop.cond)
         COND_DISPATCH: begin
            if (req_accept) begin
               case (req_opcode)
                  OP_RESTART: step_in = STEP_RESTART;
                  OP_LOAD:    step_in = STEP_LOAD;
                  OP_TICK:    step_in = STEP_FETCH;
                  default:    step_in = STEP_IDLE;
               endcase
            end
         end
         COND_OUT_FREE: begin
            if (out_free) begin
               step_in = uop.next_step;
            end
         end
         default: begin
            step_in = uop.next_step;
         end
      endcase

      if (uop.do_restart) begin
         buf_len_in = NW'(rounded_c) + NW'(1);
         wp_in      = rounded_c;
         rp_in      = (32'(string_length_ff) > limit) ? RPW'(limit)
                                                      : RPW'(string_length_ff);
         prev_in    = '0;
         lp_in      = '0;
      end

      if (uop.do_load) begin
         mem_we    = 1'b1;
         mem_waddr = lp_c;
         mem_wdata = sample_ff;
         lp_in     = (lp_p1 >= n_w) ? '0 : lp_p1[AW-1:0];
      end

      if (uop.write_back && out_free) begin
         mem_we       = 1'b1;
         prev_in      = x_ff;
         wp_in        = (wp_c == '0) ? n_m1_w[AW-1:0] : wp_c - AW'(1);
         if (rp_ff < RPW'(ONE)) begin
            rp_in = rp_ff + {n_m1_w[AW-1:0], {F{1'b0}}};
         end else begin
            rp_in = rp_ff - RPW'(ONE);
         end
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff          <= STEP_IDLE;
         rsp_valid_ff     <= 1'b0;
         buf_len_ff       <= '0;
         wp_ff            <= '0;
         rp_ff            <= '0;
         prev_ff          <= '0;
         lp_ff            <= '0;
         string_length_ff <= LENGTH_W'(25600);
         decay_gain_ff    <= GAIN_W'(65000);
      end else begin
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
         buf_len_ff   <= buf_len_in;
         wp_ff        <= wp_in;
         rp_ff        <= rp_in;
         prev_ff      <= prev_in;
         lp_ff        <= lp_in;
         if (csr_write_enable) begin
            if (csr_index == CSR_STRING_LENGTH) begin
               string_length_ff <= csr_wdata;
            end else begin
               decay_gain_ff <= csr_wdata[GAIN_W-1:0];
            end
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         sample_ff <= req_excitation_sample;
      end
      case (uop.acc_op)
         ACC_LOAD: acc_ff <= prod;
         ACC_ADD:  acc_ff <= acc_ff + prod;
         default:  acc_ff <= acc_ff;
      endcase
      if (uop.latch_x) begin
         x_ff   <= x_in;
         avg_ff <= avg_in;
      end
      if (uop.write_back && out_free) begin
         rsp_data_ff <= x_ff;
      end
   end

   // delay ring
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_raddr];
      end
   end

endmodule

FILE: sim/plucked_string_voice_checker.sv
// checker for the plucked string voice: predicts each output sample and compares it
`timescale 1ns / 1ps

module plucked_string_voice_checker
   import psv_pkg::*;
#(
   parameter int MAX_LENGTH    = 1024,
   parameter int FRACTION_BITS = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_stall,
   input  logic [1:0]                 req_opcode,
   input  logic signed [SAMPLE_W-1:0] req_excitation_sample,
   input  logic                       rsp_valid,
   input  logic                       rsp_stall,
   input  logic signed [SAMPLE_W-1:0] rsp_sample,
   input  logic                       csr_write_enable,
   input  logic                       csr_index,
   input  logic [LENGTH_W-1:0]        csr_wdata,
   input  logic                       end_of_run,
   output int                         expected_count,
   output int                         error_count
);

   localparam int ONE   = 1 << FRACTION_BITS;
   localparam int PTR_W = $clog2(MAX_LENGTH);

   logic signed [SAMPLE_W-1:0] ring [MAX_LENGTH];
   logic [PTR_W:0]             ring_len;
   logic [PTR_W-1:0]           wr_ptr;
   logic [PTR_W-1:0]           ld_ptr;
   logic [LENGTH_W-1:0]        rd_pos;
   logic signed [SAMPLE_W-1:0] prev_sample;
   logic [LENGTH_W-1:0]        string_length;
   logic [GAIN_W-1:0]          decay_gain;
   logic signed [SAMPLE_W-1:0] sample_queue [$];
   int                         errors = 0;
   bit                         leftover_done;

   assign error_count = errors;

   task automatic flag_error(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
   endtask

   function automatic logic signed [SAMPLE_W-1:0] clip_sample(input longint v);
      if (v > 32767) return 16'sh7FFF;
      if (v < -32768) return 16'sh8000;
      return v[SAMPLE_W-1:0];
   endfunction

   // a ring that was never sized behaves as a single entry
   function automatic int active_length();
      int n;
      n = int'(ring_len);
      if (n == 0) n = 1;
      if (n > MAX_LENGTH) n = MAX_LENGTH;
      return n;
   endfunction

   function automatic void restart_string();
      int     rounded;
      longint limit;
      rounded = (int'(string_length) + ONE / 2) >> FRACTION_BITS;
      if (rounded > MAX_LENGTH - 1) rounded = MAX_LENGTH - 1;
      ring_len = (PTR_W + 1)'(rounded + 1);
      wr_ptr   = PTR_W'(rounded);
      limit    = longint'(rounded + 1) * ONE - 1;
      rd_pos   = string_length;
      if (longint'(string_length) > limit) rd_pos = LENGTH_W'(limit);
      prev_sample = '0;
      ld_ptr      = '0;
   endfunction

   function automatic void load_sample(input logic signed [SAMPLE_W-1:0] s);
      int n, p;
      n = active_length();
      p = int'(ld_ptr);
      if (p >= n) p = 0;
      ring[p] = s;
      p = (p + 1 >= n) ? 0 : p + 1;
      ld_ptr = PTR_W'(p);
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] tick_string();
      int                         n, whole, nxt, frac, w;
      longint                     acc, avg;
      logic signed [SAMPLE_W-1:0] x, stored;
      n     = active_length();
      whole = int'(rd_pos) >> FRACTION_BITS;
      frac  = int'(rd_pos) & (ONE - 1);
      if (whole >= n) whole = n - 1;
      nxt = (whole + 1 >= n) ? 0 : whole + 1;
      acc = longint'(ONE - frac) * ring[whole] + longint'(frac) * ring[nxt];
      x   = clip_sample(acc >>> FRACTION_BITS);
      // two-tap average, then the loop gain; both shifts floor
      avg    = (longint'(x) + longint'(prev_sample)) >>> 1;
      stored = clip_sample((avg * longint'(decay_gain)) >>> 16);
      prev_sample = x;
      w = int'(wr_ptr);
      if (w >= n) w = n - 1;
      ring[w] = stored;
      w = (w == 0) ? n - 1 : w - 1;
      wr_ptr = PTR_W'(w);
      if (int'(rd_pos) < ONE) rd_pos = LENGTH_W'(int'(rd_pos) + (n - 1) * ONE);
      else rd_pos = LENGTH_W'(int'(rd_pos) - ONE);
      return x;
   endfunction

   always @(posedge clock) begin
      logic signed [SAMPLE_W-1:0] want;
      if (reset) begin
         ring_len      = '0;
         wr_ptr        = '0;
         ld_ptr        = '0;
         rd_pos        = '0;
         prev_sample   = '0;
         string_length = LENGTH_W'(25600);
         decay_gain    = GAIN_W'(65000);
         leftover_done = 1'b0;
         sample_queue.delete();
      end else begin
         if (csr_write_enable) begin
            if (csr_index == CSR_STRING_LENGTH) string_length = csr_wdata;
            else decay_gain = csr_wdata[GAIN_W-1:0];
         end
         if (req_valid && !req_stall) begin
            case (req_opcode)
               OP_RESTART: restart_string();
               OP_LOAD:    load_sample(req_excitation_sample);
               OP_TICK:    sample_queue.push_back(tick_string());
               default:    ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (sample_queue.size() == 0) begin
               flag_error($sformatf("output sample %0d with no tick waiting", rsp_sample));
            end else begin
               want = sample_queue.pop_front();
               if (rsp_sample !== want)
                  flag_error($sformatf("sample %0d, predicted %0d", rsp_sample, want));
            end
         end
         if (end_of_run && !leftover_done && sample_queue.size() != 0) begin
            flag_error($sformatf("%0d output samples never arrived", sample_queue.size()));
            leftover_done = 1'b1;
         end
      end
      expected_count <= sample_queue.size();
   end

endmodule

FILE: sim/plucked_string_voice_tb.sv
// testbench top for the plucked string voice: stimulus, flow control and verdict
`timescale 1ns / 1ps

module plucked_string_voice_tb;
   import psv_pkg::*;

   localparam int MAX_LENGTH    = 1024;
   localparam int FRACTION_BITS = 8;
   localparam int ONE           = 1 << FRACTION_BITS;
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int LENGTH_MAX    = (1 << LENGTH_W) - 1;
   localparam int SETTLE_CYCLES = 10;
   localparam int HOLD_CYCLES   = 400;
   localparam int ITEM_TARGET   = 1650;
   localparam int DRAIN_LIMIT   = 50000;

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   logic [1:0]                 req_opcode;
   logic signed [SAMPLE_W-1:0] req_excitation_sample;
   logic                       rsp_valid;
   logic                       rsp_stall;
   logic signed [SAMPLE_W-1:0] rsp_sample;
   logic                       csr_write_enable;
   logic                       csr_index;
   logic [LENGTH_W-1:0]        csr_wdata;
   logic                       end_of_run;
   int                         expected_count;
   int                         error_count;

   int tx_idle_pct  = 0;
   int rx_stall_pct = 0;
   int hold_request = 0;
   int hold_seen    = 0;
   int hold_left    = 0;
   int items_sent   = 0;
   int filled_len   = 0;   // ring entries 0 .. filled_len-1 hold written samples
   int cur_length   = 25600;

   plucked_string_voice #(
      .MAX_LENGTH(MAX_LENGTH),
      .FRACTION_BITS(FRACTION_BITS)
   ) uut (.*);

   plucked_string_voice_checker #(
      .MAX_LENGTH(MAX_LENGTH),
      .FRACTION_BITS(FRACTION_BITS)
   ) sample_check (.*);

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   initial begin
      #24_000_000;
      $display("*** FAILED ***");
      $finish;
   end

   // output side: random stalls, plus one long hold-off on request
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_seen != hold_request) begin
         hold_seen <= hold_request;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= (rx_stall_pct != 0) && ($urandom_range(0, 99) < rx_stall_pct);
      end
   end

   task automatic offer(input logic [1:0] op, input logic signed [SAMPLE_W-1:0] smp);
      while (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid             <= 1'b1;
      req_opcode            <= op;
      req_excitation_sample <= smp;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (op != OP_UNUSED) items_sent++;
   endtask

   task automatic write_reg(input logic idx, input logic [LENGTH_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_wdata        <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
      if (idx == CSR_STRING_LENGTH) cur_length = int'(data);
   endtask

   // loads leave no output sample, so a settling wait follows once no output sample is pending
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_traffic(input int mode);
      case (mode)
         0: begin tx_idle_pct = 0;  rx_stall_pct <= 0;  end
         1: begin tx_idle_pct = 58; rx_stall_pct <= 0;  end
         2: begin tx_idle_pct = 0;  rx_stall_pct <= 58; end
         default: begin tx_idle_pct = 29; rx_stall_pct <= 29; end
      endcase
   endtask

   function automatic int ring_entries(input int len);
      int rounded;
      rounded = (len + ONE / 2) >> FRACTION_BITS;
      if (rounded > MAX_LENGTH - 1) rounded = MAX_LENGTH - 1;
      return rounded + 1;
   endfunction

   function automatic logic [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(0, 9))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         3: return 16'hFFFF;
         default: return SAMPLE_W'($urandom_range(0, 65535));
      endcase
   endfunction

   function automatic logic [LENGTH_W-1:0] pick_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 5) return '0;
      if (r < 10) return LENGTH_W'(512);
      // an exact half sample rounds up
      if (r < 16) return LENGTH_W'(ONE / 2 + ONE * $urandom_range(1, 30));
      if (r < 20) return LENGTH_W'(LENGTH_MAX);
      if (r < 23) return LENGTH_W'(261632);
      if (r < 30) return LENGTH_W'($urandom_range(0, LENGTH_MAX));
      if (r < 85) return LENGTH_W'($urandom_range(0, 10000));
      return LENGTH_W'($urandom_range(10000, 40000));
   endfunction

   function automatic logic [LENGTH_W-1:0] pick_gain();
      logic [GAIN_W-1:0] g;
      case ($urandom_range(0, 5))
         0: g = '0;
         1: g = '1;
         default: g = GAIN_W'($urandom_range(0, 65535));
      endcase
      // the unused upper bits of the write data are exercised too
      return {2'($urandom_range(0, 3)), g};
   endfunction

   // restart, fill the ring (fully, or partly where old samples already cover it), then play
   task automatic play_note(input int body_ops);
      int n, loads, r;
      n = ring_entries(cur_length);
      offer(OP_RESTART, pick_sample());
      if (n <= filled_len && (n > 48 || $urandom_range(0, 2) == 0)) begin
         loads = $urandom_range(0, (n < 48) ? n - 1 : 47);
      end else begin
         loads = n + $urandom_range(0, 2);
         if (n > filled_len) filled_len = n;
      end
      repeat (loads) offer(OP_LOAD, pick_sample());
      for (int i = 0; i < body_ops; i++) begin
         r = $urandom_range(0, 99);
         if (r < 76) offer(OP_TICK, pick_sample());
         else if (r < 88) offer(OP_LOAD, pick_sample());
         else if (r < 95) offer(OP_UNUSED, pick_sample());
         else offer(OP_RESTART, pick_sample());
      end
   endtask

   initial begin
      int seg;
      int drain;
      reset                 <= 1'b1;
      req_valid             <= 1'b0;
      req_opcode            <= OP_RESTART;
      req_excitation_sample <= '0;
      rsp_stall             <= 1'b0;
      csr_write_enable      <= 1'b0;
      csr_index             <= CSR_STRING_LENGTH;
      csr_wdata             <= '0;
      end_of_run            <= 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // never restarted: the ring acts as a single entry
      set_traffic(0);
      offer(OP_LOAD, 16'sh8000);
      filled_len = 1;
      offer(OP_TICK, 16'sh0000);
      offer(OP_TICK, 16'shFFFF);
      offer(OP_UNUSED, 16'sh5A5A);
      wait_idle();

      // 3.5 samples rounds up to a ring of five, full gain
      write_reg(CSR_STRING_LENGTH, LENGTH_W'(ONE * 3 + ONE / 2));
      write_reg(CSR_DECAY_GAIN, LENGTH_W'(16'hFFFF));
      offer(OP_RESTART, 16'sh0000);
      offer(OP_LOAD, 16'sh7FFF);
      offer(OP_LOAD, 16'sh8000);
      offer(OP_LOAD, 16'sh0000);
      offer(OP_LOAD, 16'shFFFF);
      offer(OP_LOAD, 16'sh0001);
      filled_len = 5;
      repeat (6) offer(OP_TICK, 16'sh0000);
      wait_idle();

      // zero length and zero gain
      write_reg(CSR_STRING_LENGTH, '0);
      write_reg(CSR_DECAY_GAIN, '0);
      offer(OP_RESTART, 16'sh0000);
      offer(OP_TICK, 16'sh0000);
      offer(OP_TICK, 16'sh0000);

      items_sent = 0;
      seg = 0;
      while (items_sent < ITEM_TARGET) begin
         wait_idle();
         set_traffic(seg % 4);
         if (seg == 0) begin
            // overlong string saturates the ring at full size and fills every entry
            write_reg(CSR_STRING_LENGTH, LENGTH_W'(LENGTH_MAX));
            write_reg(CSR_DECAY_GAIN, pick_gain());
            play_note(40);
         end else begin
            if ($urandom_range(0, 3) != 0) write_reg(CSR_STRING_LENGTH, pick_length());
            else write_reg(CSR_DECAY_GAIN, pick_gain());
            if ($urandom_range(0, 1) == 0) write_reg(CSR_DECAY_GAIN, pick_gain());
            if (seg == 2) hold_request <= hold_request + 1;
            repeat ($urandom_range(1, 2)) play_note((seg == 2) ? 40 : $urandom_range(4, 40));
         end
         seg++;
      end

      req_valid <= 1'b0;
      drain = 0;
      @(posedge clock);
      while (expected_count != 0 && drain < DRAIN_LIMIT) begin
         @(posedge clock);
         drain++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      end_of_run <= 1'b1;
      repeat (2) @(posedge clock);
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
